>>> sv/cluster_bounding_boxes_macros.svh
// Assertion macros used by the cluster bounding box checker
`ifndef CLUSTER_BOUNDING_BOXES_MACROS_SVH
`define CLUSTER_BOUNDING_BOXES_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define CBB_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted
`define CBB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> sv/cbb_pkg.sv
// Shared types and constants for the cluster bounding box block
`timescale 1ns / 1ps

package cbb_pkg;

  // Width of the incoming signed label and of the emitted box label
  localparam int unsigned LABEL_IN_BITS  = 9;
  localparam int unsigned BOX_LABEL_BITS = 5;

  // Label code for an unclassified point
  localparam logic [LABEL_IN_BITS-1:0] LABEL_UNCLASSIFIED = '1;

  // Depth of the queue between the front and the back
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_BITS = $clog2(QDEPTH);

  // Bit positions in the result tuser
  localparam int unsigned OUT_TUSER_BITS  = 2;
  localparam int unsigned TUSER_BOX_VALID = 0;
  localparam int unsigned TUSER_OVERFLOW  = 1;

  // Per-word control that rides along with the queued coordinates
  typedef struct packed {
    logic drop;  // label out of range, point is not recorded
    logic last;  // final point of the frame
  } cbb_ctl_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    ST_RUN,    // update the table from queued points
    ST_SCAN,   // step through labels looking for a filled entry
    ST_LOAD,   // corner data back from the table, build a box
    ST_FLUSH   // emit the final result of the frame and clear
  } cbb_state_e;

endpackage

>>> sv/cluster_bounding_boxes.sv
// Top level: per-label bounding boxes over a stream of labelled points
// Points: one word per cycle while the queue has room; each point passes through the queue
// and the update stage before it updates its label's corners. Frame end: the label walk
// checks each label in turn and reads back the corners of each filled label to build a box.
// A 4-word queue keeps taking points during the walk; the corner table has a single read port.
// Reset clears the queue, seen marks, overflow flag and result valid; corners stay undefined.
`timescale 1ns / 1ps

module cluster_bounding_boxes #(
  parameter int unsigned MAX_LABELS = 32,
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned InDataW  = ((3*COORD_BITS + cbb_pkg::LABEL_IN_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((6*COORD_BITS + cbb_pkg::BOX_LABEL_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // point_x, point_y, point_z, label
  input  logic [InDataW-1:0]                 s_axis_tdata,
  // last_point
  input  logic                               s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // box_label, centre_x, centre_y, centre_z, extent_x, extent_y, extent_z
  output logic [OutDataW-1:0]                m_axis_tdata,
  // box_valid, label_overflow
  output logic [cbb_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,
  // last_box
  output logic                               m_axis_tlast
);
  import cbb_pkg::*;

  localparam int unsigned IdxBits = $clog2(MAX_LABELS);
  localparam int unsigned PW      = 3 * COORD_BITS;

  logic                  q_valid, q_pop;
  logic [PW-1:0]         q_pts;
  logic [IdxBits-1:0]    q_idx;
  cbb_ctl_t              q_ctl;
  logic [BOX_LABEL_BITS-1:0] box_label;
  logic [PW-1:0]         centre, extent;
  logic                  box_valid, overflow;

  cbb_front #(
    .MAX_LABELS (MAX_LABELS),
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (IdxBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .pts_i     (s_axis_tdata[PW-1:0]),
    .label_i   (s_axis_tdata[PW +: LABEL_IN_BITS]),
    .last_i    (s_axis_tlast),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_pts_o   (q_pts),
    .q_idx_o   (q_idx),
    .q_ctl_o   (q_ctl)
  );

  cbb_back #(
    .MAX_LABELS (MAX_LABELS),
    .COORD_BITS (COORD_BITS),
    .IDX_BITS   (IdxBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_pts_i       (q_pts),
    .q_idx_i       (q_idx),
    .q_ctl_i       (q_ctl),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_label_o     (box_label),
    .m_centre_o    (centre),
    .m_extent_o    (extent),
    .m_box_valid_o (box_valid),
    .m_overflow_o  (overflow),
    .m_last_o      (m_axis_tlast)
  );

  // Pack the result word, label in the lowest bits
  assign m_axis_tdata = OutDataW'({extent, centre, box_label});
  always_comb begin
    m_axis_tuser                  = '0;
    m_axis_tuser[TUSER_BOX_VALID] = box_valid;
    m_axis_tuser[TUSER_OVERFLOW]  = overflow;
  end

endmodule

>>> sv/cbb_front.sv
// Front end: classify the label of each point and queue it for the back end
`timescale 1ns / 1ps

module cbb_front #(
  parameter int unsigned MAX_LABELS = 32,
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned IDX_BITS   = $clog2(MAX_LABELS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [3*COORD_BITS-1:0]           pts_i,
  input  logic [cbb_pkg::LABEL_IN_BITS-1:0] label_i,
  input  logic                              last_i,
  output logic                              q_valid_o,
  input  logic                              q_pop_i,
  output logic [3*COORD_BITS-1:0]           q_pts_o,
  output logic [IDX_BITS-1:0]               q_idx_o,
  output cbb_pkg::cbb_ctl_t                 q_ctl_o
);
  import cbb_pkg::*;

  localparam logic [LABEL_IN_BITS-1:0] LabelLimit = LABEL_IN_BITS'(MAX_LABELS);

  logic                  is_unc;
  logic                  drop;
  logic [IDX_BITS-1:0]   idx;
  cbb_ctl_t              ctl;
  logic                  push;

  logic [3*COORD_BITS-1:0] pts_q [QDEPTH];
  logic [IDX_BITS-1:0]     idx_q [QDEPTH];
  cbb_ctl_t                ctl_q [QDEPTH];
  logic [QPTR_BITS-1:0]    wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]    rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]      cnt_q, cnt_d;

  // Fold unclassified into label 0, flag anything outside the table
  always_comb begin
    is_unc = (label_i == LABEL_UNCLASSIFIED);
    drop   = (label_i[LABEL_IN_BITS-1] && !is_unc) ||
             (!label_i[LABEL_IN_BITS-1] &&
              ({1'b0, label_i[LABEL_IN_BITS-2:0]} >= LabelLimit));
    idx    = is_unc ? '0 : label_i[IDX_BITS-1:0];
    ctl    = '{drop: drop, last: last_i};
  end

  // Queue handshake and pointers
  assign ready_o   = (cnt_q != (QPTR_BITS+1)'(QDEPTH));
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != '0);
  assign q_pts_o   = pts_q[rd_ptr_q];
  assign q_idx_o   = idx_q[rd_ptr_q];
  assign q_ctl_o   = ctl_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified word
  always_ff @(posedge clk_i) begin
    if (push) begin
      pts_q[wr_ptr_q] <= pts_i;
      idx_q[wr_ptr_q] <= idx;
      ctl_q[wr_ptr_q] <= ctl;
    end
  end

endmodule

>>> sv/cbb_back.sv
// Back end: per-label corner table, end-of-frame label walk and result register
`timescale 1ns / 1ps

module cbb_back #(
  parameter int unsigned MAX_LABELS = 32,
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned IDX_BITS   = $clog2(MAX_LABELS)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               q_valid_i,
  output logic                               q_pop_o,
  input  logic [3*COORD_BITS-1:0]            q_pts_i,
  input  logic [IDX_BITS-1:0]                q_idx_i,
  input  cbb_pkg::cbb_ctl_t                  q_ctl_i,
  output logic                               m_valid_o,
  input  logic                               m_ready_i,
  output logic [cbb_pkg::BOX_LABEL_BITS-1:0] m_label_o,
  output logic [3*COORD_BITS-1:0]            m_centre_o,
  output logic [3*COORD_BITS-1:0]            m_extent_o,
  output logic                               m_box_valid_o,
  output logic                               m_overflow_o,
  output logic                               m_last_o
);
  import cbb_pkg::*;

  localparam int unsigned PW = 3 * COORD_BITS;
  localparam logic [IDX_BITS-1:0] KLast  = IDX_BITS'(MAX_LABELS - 1);
  localparam logic [IDX_BITS-1:0] KFirst = IDX_BITS'(1);

  // Corner table
  logic [PW-1:0] min_mem [MAX_LABELS];
  logic [PW-1:0] max_mem [MAX_LABELS];
  logic [PW-1:0] rd_min_q, rd_max_q;
  logic          rd_en;
  logic [IDX_BITS-1:0] rd_addr;

  // Sequencer
  cbb_state_e          state_q, state_d;
  logic [IDX_BITS-1:0] k_q, k_d;
  logic                hold_q;
  logic [MAX_LABELS-1:0] seen_q;
  logic                ovf_q;
  logic                pop, k_seen, k_end, out_free;
  logic                scan_rd, load_go, flush_go, k_step;

  // Update stage
  logic                u_valid_q;
  logic [IDX_BITS-1:0] u_idx_q;
  logic [PW-1:0]       u_pts_q;
  cbb_ctl_t            u_ctl_q;
  logic                we, fwd, seen_u;
  logic [PW-1:0]       cur_min, cur_max, new_min, new_max;

  // Last write, for a back-to-back update of the same label
  logic                w_valid_q;
  logic [IDX_BITS-1:0] w_idx_q;
  logic [PW-1:0]       w_min_q, w_max_q;

  // Box arithmetic
  logic [PW-1:0] box_centre, box_extent;

  // One box held back until it is known whether it closes the frame
  logic                      pend_valid_q;
  logic [BOX_LABEL_BITS-1:0] pend_label_q;
  logic [PW-1:0]             pend_centre_q, pend_extent_q;

  // Result register
  logic                      o_valid_q;
  logic [BOX_LABEL_BITS-1:0] o_label_q;
  logic [PW-1:0]             o_centre_q, o_extent_q;
  logic                      o_box_q, o_ovf_q, o_last_q;

  assign pop      = q_valid_i && (state_q == ST_RUN) && !hold_q;
  assign q_pop_o  = pop;
  assign k_seen   = seen_q[k_q];
  assign k_end    = (k_q == KLast);
  assign out_free = !o_valid_q || m_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (u_valid_q && u_ctl_q.last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (k_seen) begin
          state_d = ST_LOAD;
        end else if (k_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_LOAD: begin
        if (!pend_valid_q || out_free) begin
          state_d = k_end ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Sequencer strobes
  always_comb begin
    scan_rd  = 1'b0;
    load_go  = 1'b0;
    flush_go = 1'b0;
    k_step   = 1'b0;
    case (state_q)
      ST_SCAN: begin
        scan_rd = k_seen;
        k_step  = !k_seen && !k_end;
      end
      ST_LOAD: begin
        load_go = !pend_valid_q || out_free;
        k_step  = load_go && !k_end;
      end
      ST_FLUSH: begin
        flush_go = out_free;
      end
      default: begin
        scan_rd = 1'b0;
      end
    endcase
    if (flush_go) begin
      k_d = KFirst;
    end else if (k_step) begin
      k_d = k_q + 1'b1;
    end else begin
      k_d = k_q;
    end
  end

  assign rd_en   = pop || scan_rd;
  assign rd_addr = pop ? q_idx_i : k_q;

  // Merge the point into its label's corners
  assign we     = u_valid_q && !u_ctl_q.drop;
  assign fwd    = w_valid_q && (w_idx_q == u_idx_q);
  assign seen_u = seen_q[u_idx_q];
  assign cur_min = fwd ? w_min_q : rd_min_q;
  assign cur_max = fwd ? w_max_q : rd_max_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [COORD_BITS-1:0] p, mn, mx, tmn, tmx;
    logic signed [COORD_BITS:0]   sum;

    assign p   = $signed(u_pts_q[a*COORD_BITS +: COORD_BITS]);
    assign mn  = $signed(cur_min[a*COORD_BITS +: COORD_BITS]);
    assign mx  = $signed(cur_max[a*COORD_BITS +: COORD_BITS]);
    assign new_min[a*COORD_BITS +: COORD_BITS] = (!seen_u || p < mn) ? p : mn;
    assign new_max[a*COORD_BITS +: COORD_BITS] = (!seen_u || p > mx) ? p : mx;

    // Centre is the floor of the half sum, extent the plain difference
    assign tmn = $signed(rd_min_q[a*COORD_BITS +: COORD_BITS]);
    assign tmx = $signed(rd_max_q[a*COORD_BITS +: COORD_BITS]);
    assign sum = {tmn[COORD_BITS-1], tmn} + {tmx[COORD_BITS-1], tmx};
    assign box_centre[a*COORD_BITS +: COORD_BITS] = sum[COORD_BITS:1];
    assign box_extent[a*COORD_BITS +: COORD_BITS] = tmx - tmn;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_RUN;
      k_q          <= KFirst;
      hold_q       <= 1'b0;
      seen_q       <= '0;
      ovf_q        <= 1'b0;
      u_valid_q    <= 1'b0;
      w_valid_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      u_valid_q <= pop;
      w_valid_q <= we;
      if (flush_go) begin
        hold_q <= 1'b0;
      end else if (pop && q_ctl_i.last) begin
        hold_q <= 1'b1;
      end
      if (flush_go) begin
        seen_q <= '0;
      end else if (we) begin
        seen_q[u_idx_q] <= 1'b1;
      end
      if (flush_go) begin
        ovf_q <= 1'b0;
      end else if (u_valid_q && u_ctl_q.drop) begin
        ovf_q <= 1'b1;
      end
      if (flush_go) begin
        pend_valid_q <= 1'b0;
      end else if (load_go) begin
        pend_valid_q <= 1'b1;
      end
      if ((load_go && pend_valid_q) || flush_go) begin
        o_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Corner table: one write port, one registered read port per corner
  always_ff @(posedge clk_i) begin
    if (we) begin
      min_mem[u_idx_q] <= new_min;
      max_mem[u_idx_q] <= new_max;
    end
    if (rd_en) begin
      rd_min_q <= min_mem[rd_addr];
      rd_max_q <= max_mem[rd_addr];
    end
  end

  // Pipeline and result payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      u_idx_q <= q_idx_i;
      u_pts_q <= q_pts_i;
      u_ctl_q <= q_ctl_i;
    end
    if (we) begin
      w_idx_q <= u_idx_q;
      w_min_q <= new_min;
      w_max_q <= new_max;
    end
    if (load_go) begin
      pend_label_q  <= BOX_LABEL_BITS'(k_q);
      pend_centre_q <= box_centre;
      pend_extent_q <= box_extent;
    end
    if (load_go && pend_valid_q) begin
      o_label_q  <= pend_label_q;
      o_centre_q <= pend_centre_q;
      o_extent_q <= pend_extent_q;
      o_box_q    <= 1'b1;
      o_ovf_q    <= ovf_q;
      o_last_q   <= 1'b0;
    end else if (flush_go) begin
      o_label_q  <= pend_valid_q ? pend_label_q : '0;
      o_centre_q <= pend_valid_q ? pend_centre_q : '0;
      o_extent_q <= pend_valid_q ? pend_extent_q : '0;
      o_box_q    <= pend_valid_q;
      o_ovf_q    <= ovf_q;
      o_last_q   <= 1'b1;
    end
  end

  assign m_valid_o     = o_valid_q;
  assign m_label_o     = o_label_q;
  assign m_centre_o    = o_centre_q;
  assign m_extent_o    = o_extent_q;
  assign m_box_valid_o = o_box_q;
  assign m_overflow_o  = o_ovf_q;
  assign m_last_o      = o_last_q;

endmodule

>>> sv/cbb_checker.sv
// Port-level checks for the cluster bounding box block, bound to the top level
`timescale 1ns / 1ps
`include "cluster_bounding_boxes_macros.svh"

module cbb_checker #(
  parameter int unsigned MAX_LABELS = 32,
  parameter int unsigned COORD_BITS = 24,
  localparam int unsigned InDataW  = ((3*COORD_BITS + cbb_pkg::LABEL_IN_BITS + 7) / 8) * 8,
  localparam int unsigned OutDataW = ((6*COORD_BITS + cbb_pkg::BOX_LABEL_BITS + 7) / 8) * 8
) (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [InDataW-1:0]                 s_axis_tdata,
  input logic                               s_axis_tlast,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [OutDataW-1:0]                m_axis_tdata,
  input logic [cbb_pkg::OUT_TUSER_BITS-1:0] m_axis_tuser,
  input logic                               m_axis_tlast
);
  import cbb_pkg::*;

  logic                               out_stall;
  logic                               out_take;
  logic                               out_empty;
  logic                               ovf_now;
  logic [OutDataW+OUT_TUSER_BITS:0]   out_word;

  // Shorthand for the result side
  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_take  = m_axis_tvalid && m_axis_tready && !m_axis_tlast;
  assign out_empty = m_axis_tvalid && !m_axis_tuser[TUSER_BOX_VALID];
  assign ovf_now   = m_axis_tuser[TUSER_OVERFLOW];
  assign out_word  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // No result is offered in the cycle after reset is seen
  `CBB_ASSERT_ALWAYS(a_no_word_in_reset, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

  // A stalled result stays offered and unchanged
  `CBB_ASSERT_CLK(a_out_hold, out_stall |=> m_axis_tvalid, "result dropped")
  `CBB_ASSERT_CLK(a_out_stable, out_stall |=> $stable(out_word), "result changed while stalled")

  // An empty-frame word closes the frame and carries all zeros
  `CBB_ASSERT_CLK(a_empty_shape, out_empty |-> m_axis_tlast && (m_axis_tdata == '0), "bad empty")

  // The overflow flag is the same on every word of a frame
  `CBB_ASSERT_CLK(a_ovf_frame, out_take |=> !m_axis_tvalid || (ovf_now == $past(ovf_now)), "ovf")

endmodule

bind cluster_bounding_boxes cbb_checker #(
  .MAX_LABELS (MAX_LABELS),
  .COORD_BITS (COORD_BITS)
) u_cbb_checker (.*);
